// ===== rtl/core/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and key schedule functions for the Simon 128/256
// block cipher core.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int ROUNDS     = 72;
   localparam int KEY_WORDS  = 4;
   localparam int WORD_W     = 64;
   localparam int KS_STEPS   = ROUNDS - KEY_WORDS;
   localparam int CNT_W      = $clog2(KS_STEPS + 1);
   localparam int Z_PERIOD   = 62;
   localparam int Z_W        = $clog2(Z_PERIOD);
   localparam int CSR_IDX_W  = 3;

   localparam logic [WORD_W-1:0] Z4_SEQ   = 64'h3DC9_4C3A_046D_678B;
   localparam logic [WORD_W-1:0] KS_CONST = 64'd3;

   // request command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_WORD0    = 3'd0,
      CSR_KEY_WORD1    = 3'd1,
      CSR_KEY_WORD2    = 3'd2,
      CSR_KEY_WORD3    = 3'd3,
      CSR_VARIANT_MODE = 3'd4
   } csr_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_window_type;

   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] block_word0;
      logic [WORD_W-1:0] block_word1;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word0;
      logic [WORD_W-1:0] result_word1;
   } rsp_type;

   // what one round cell holds; keys[0] is the oldest round key of the window
   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      key_window_type    keys;
   } round_data_type;

   typedef struct packed {
      logic           valid;
      round_data_type data;
   } stage_type;

   function automatic logic [WORD_W-1:0] ror3_mix(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] t;
      t = {a[2:0], a[WORD_W-1:3]} ^ b;
      return t ^ {t[0], t[WORD_W-1:1]};
   endfunction

   // k[i+4] from the window k[i..i+3]
   function automatic logic [WORD_W-1:0] key_fwd(input key_window_type w, input logic z);
      return ~w[0] ^ ror3_mix(w[3], w[1]) ^ {{(WORD_W-1){1'b0}}, z} ^ KS_CONST;
   endfunction

   // k[r-4] from the window k[r-3..r]
   function automatic logic [WORD_W-1:0] key_rev(input key_window_type w, input logic z);
      return ~w[3] ^ ror3_mix(w[2], w[0]) ^ {{(WORD_W-1){1'b0}}, z} ^ KS_CONST;
   endfunction

   // z bit used by the forward step of round cell idx
   function automatic logic z_fwd_bit(input int idx);
      return Z4_SEQ[idx % Z_PERIOD];
   endfunction

   // z bit used by the reverse step of round cell idx (decrypt order)
   function automatic logic z_rev_bit(input int idx);
      int r;
      r = ROUNDS - 1 - idx;
      if (r < KEY_WORDS) begin
         return 1'b0;
      end
      return Z4_SEQ[(r - KEY_WORDS) % Z_PERIOD];
   endfunction

endpackage

// ===== rtl/core/sbc_round_cell.sv =====
// ----------------------------------------------------------------------------
// sbc_round_cell
// One Simon round plus one key schedule step, forward or reverse by command.
// ----------------------------------------------------------------------------
module sbc_round_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               variant,
   input  logic               z_fwd,
   input  logic               z_rev,
   input  sbc_pkg::stage_type up_in,
   output sbc_pkg::stage_type down_out
);
   import sbc_pkg::*;

   logic              valid_ff;
   round_data_type    data_ff;
   round_data_type    data_in;
   logic              decrypt;
   logic [WORD_W-1:0] x;
   logic [WORD_W-1:0] y;
   logic [WORD_W-1:0] rk;
   logic [WORD_W-1:0] a;
   logic [WORD_W-1:0] b;
   logic [WORD_W-1:0] mixed;

   always_comb begin
      decrypt = (up_in.data.cmd == CMD_DECRYPT);
      // decrypt swaps the roles of the two words
      x  = decrypt ? up_in.data.word0 : up_in.data.word1;
      y  = decrypt ? up_in.data.word1 : up_in.data.word0;
      rk = decrypt ? up_in.data.keys[KEY_WORDS-1] : up_in.data.keys[0];
      a  = {x[WORD_W-2:0], x[WORD_W-1]};
      b  = {x[WORD_W-9:0], x[WORD_W-1:WORD_W-8]};
      mixed = (variant ? (a ^ b) : (a & b)) ^ {x[WORD_W-3:0], x[WORD_W-1:WORD_W-2]}
              ^ y ^ rk;
      data_in.cmd = up_in.data.cmd;
      if (decrypt) begin
         data_in.word0   = mixed;
         data_in.word1   = x;
         data_in.keys[0] = key_rev(up_in.data.keys, z_rev);
         for (int i = 1; i < KEY_WORDS; i++) begin
            data_in.keys[i] = up_in.data.keys[i-1];
         end
      end else begin
         data_in.word0 = x;
         data_in.word1 = mixed;
         for (int i = 0; i < KEY_WORDS - 1; i++) begin
            data_in.keys[i] = up_in.data.keys[i+1];
         end
         data_in.keys[KEY_WORDS-1] = key_fwd(up_in.data.keys, z_fwd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign down_out.valid = valid_ff;
   assign down_out.data  = data_ff;

endmodule

// ===== rtl/core/sbc_key_sched.sv =====
// ----------------------------------------------------------------------------
// sbc_key_sched
// Runs the key schedule forward once per key change to find the last four
// round keys, which seed the decrypt direction of the round chain.
// ----------------------------------------------------------------------------
module sbc_key_sched (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    restart,
   input  sbc_pkg::key_window_type key_words,
   output logic                    busy,
   output sbc_pkg::key_window_type last_keys
);
   import sbc_pkg::*;

   logic           load_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [Z_W-1:0] zidx_ff;
   key_window_type win_ff;
   key_window_type win_in;
   logic           running;

   assign running = (cnt_ff != CNT_W'(KS_STEPS));

   always_comb begin
      for (int i = 0; i < KEY_WORDS - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[KEY_WORDS-1] = key_fwd(win_ff, Z4_SEQ[zidx_ff]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b1;
         cnt_ff  <= '0;
         zidx_ff <= '0;
      end else if (restart) begin
         load_ff <= 1'b1;
      end else if (load_ff) begin
         load_ff <= 1'b0;
         cnt_ff  <= '0;
         zidx_ff <= '0;
      end else if (running) begin
         cnt_ff  <= cnt_ff + CNT_W'(1);
         zidx_ff <= (zidx_ff == Z_W'(Z_PERIOD - 1)) ? '0 : zidx_ff + Z_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         win_ff <= key_words;
      end else if (running) begin
         win_ff <= win_in;
      end
   end

   assign busy      = load_ff || running;
   assign last_keys = win_ff;

endmodule

// ===== rtl/core/simon_block_cipher_128_256.sv =====
// ----------------------------------------------------------------------------
// simon_block_cipher_128_256
// Simon 128/256 encrypt/decrypt core built as a chain of 72 round cells.
// ----------------------------------------------------------------------------
// A new 128-bit block can enter every cycle while req_stall is low; the
// accepting edge loads the first of 72 round cells, the block then walks the
// chain, and the last cell loads the output register, which presents the
// result on rsp. Every cell does one round and one key schedule step on a
// four-word round key window that travels with the block, so encrypt and
// decrypt blocks mix freely in the chain. Decrypt starts from the last four
// round keys, which a small sequencer derives by stepping the schedule
// forward: after reset and after any key word write, req_stall stays high
// while the sequencer does one load and 68 schedule steps. The variant_mode
// bit and the key words must only be written while no transaction is in
// flight. A one-entry skid behind the output register lets the chain keep
// moving while rsp_stall is high; the chain freezes only when the skid is
// full.
// ----------------------------------------------------------------------------
module simon_block_cipher_128_256 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sbc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sbc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sbc_pkg::WORD_W-1:0]            csr_data
);
   import sbc_pkg::*;

   // configuration registers
   key_window_type key_ff;
   logic           variant_ff;
   logic           csr_write;
   logic           key_write;

   // key sequencer
   logic           key_busy;
   key_window_type last_keys;

   // round chain; stage[0] is the request, stage[ROUNDS] the last cell
   stage_type      stage [0:ROUNDS];
   logic           advance;
   logic           req_accept;

   // output register and skid
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   logic           skid_valid_ff;
   rsp_type        skid_data_ff;
   rsp_type        last_rsp;
   logic           last_push;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      key_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_WORD0, CSR_KEY_WORD1,
            CSR_KEY_WORD2, CSR_KEY_WORD3: key_write = 1'b1;
            default:                      key_write = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         variant_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_WORD0:    key_ff[0]  <= csr_data;
            CSR_KEY_WORD1:    key_ff[1]  <= csr_data;
            CSR_KEY_WORD2:    key_ff[2]  <= csr_data;
            CSR_KEY_WORD3:    key_ff[3]  <= csr_data;
            CSR_VARIANT_MODE: variant_ff <= csr_data[0];
            default:          ;  // out-of-range index: dropped
         endcase
      end
   end

   // re-derive the decrypt seed whenever a key word changes
   sbc_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .restart   (key_write),
      .key_words (key_ff),
      .busy      (key_busy),
      .last_keys (last_keys)
   );

   // ------------------------------------------------------------ round chain
   // chain moves every cycle unless the skid already holds a result
   assign advance    = !skid_valid_ff;
   assign req_stall  = skid_valid_ff || key_busy;
   assign req_accept = req_valid && !req_stall;

   assign stage[0].valid      = req_accept;
   assign stage[0].data.cmd   = req_data.cmd;
   assign stage[0].data.word0 = req_data.block_word0;
   assign stage[0].data.word1 = req_data.block_word1;
   // encrypt walks the keys up from k[0..3], decrypt down from k[68..71]
   assign stage[0].data.keys  = (req_data.cmd == CMD_DECRYPT) ? last_keys : key_ff;

   for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
      sbc_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .variant  (variant_ff),
         .z_fwd    (z_fwd_bit(g)),
         .z_rev    (z_rev_bit(g)),
         .up_in    (stage[g]),
         .down_out (stage[g+1])
      );
   end

   // ------------------------------------------------------- output and skid
   assign last_rsp.result_word0 = stage[ROUNDS].data.word0;
   assign last_rsp.result_word1 = stage[ROUNDS].data.word1;
   assign last_push             = stage[ROUNDS].valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= last_push;
         end
      end else if (last_push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : last_rsp;
      end else if (last_push) begin
         skid_data_ff <= last_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------- checks
   // the skid only ever backs up a full, stalled output register
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a transaction while output register is empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   // a key write must be followed by key_busy and req_stall, so requests wait while the decrypt seed is rebuilt
   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      key_write |=> key_busy && req_stall)
      else $error("request channel open right after a key write");

   // a frozen chain must not lose or make up its last result
   a_freeze_holds_last: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage[ROUNDS].valid))
      else $error("last round cell changed while the chain was frozen");

endmodule
